// ===== hw/rtl/dtqtm_pkg.sv =====
package dtqtm_pkg;

  // Field widths fixed by the record format
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned PAYOUT_W = 32;
  localparam int unsigned LOST_W   = 32;

  // Operation codes (tuser bit 0)
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Queue selectors (tuser bit 1, result pop_source)
  localparam logic SRC_TASK = 1'b0;
  localparam logic SRC_ISR  = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  // Result item, packed so that push_accepted sits at bit 0
  typedef struct packed {
    logic [3:0]          pad;
    logic [LOST_W-1:0]   lost_total;
    logic [PAYOUT_W-1:0] pop_payload;
    logic [STAMP_W-1:0]  pop_stamp;
    logic                pop_source;
    logic                pop_valid;
    logic                push_dropped;
    logic                push_accepted;
  } result_t;

endpackage

// ===== hw/rtl/dual_trace_queue_timestamp_merge_unit.sv =====
// Channel    | Dir | Fields (low bit up)
// s_axis     | in  | tdata: stamp[31:0], payload[63:32]; tuser: op[0], source[1]
// m_axis     | out | tdata: push_accepted, push_dropped, pop_valid, pop_source,
//            |     |        pop_stamp[35:4], pop_payload[67:36], lost_total[99:68]
// cfg        | in  | cfg_we_i / cfg_wdata_i: enable register
//
// Each item takes an accept step and an execute step, split by the registered
// memory read: the accept cycle issues the head reads of both queue memories,
// and the execute state uses the read data to merge, write back and update pointers.
// The result register lets an item be accepted while the previous result waits.
// A stalled result holds the execute cycle until it is taken.
// Reset clears pointers, fill counts, lost counter and enable; memories are not
// cleared (entries are read only once written).
module dual_trace_queue_timestamp_merge_unit #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,  // stamp[31:0], payload[63:32]
  input  logic [1:0]   s_axis_tuser_i,  // op[0], source[1]
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [103:0] m_axis_tdata_o   // push_accepted, push_dropped, pop_valid,
                                        // pop_source, pop_stamp, pop_payload,
                                        // lost_total, zero pad
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = dtqtm_pkg::STAMP_W + PAYLOAD_BITS;
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FullLvl = FW'(QUEUE_DEPTH);

  dtqtm_pkg::state_e state_q, state_d;

  logic enable_q;
  logic op_q, src_q;
  logic [dtqtm_pkg::STAMP_W-1:0] stamp_q;
  logic [PAYLOAD_BITS-1:0]       pay_q;

  logic [AW-1:0] task_wr_q, task_wr_d, task_rd_q, task_rd_d;
  logic [AW-1:0] isr_wr_q, isr_wr_d, isr_rd_q, isr_rd_d;
  logic [FW-1:0] task_fill_q, task_fill_d, isr_fill_q, isr_fill_d;
  logic [dtqtm_pkg::LOST_W-1:0] lost_q, lost_d;

  logic [EW-1:0] task_mem [QUEUE_DEPTH];
  logic [EW-1:0] isr_mem  [QUEUE_DEPTH];
  logic [EW-1:0] task_rdata_q, isr_rdata_q;

  dtqtm_pkg::result_t res_q, res_d;
  logic out_valid_q;

  logic in_xfer, finish;
  logic task_we, isr_we;
  logic [EW-1:0] wr_entry;

  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign finish  = (state_q == dtqtm_pkg::ST_EXEC) && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = (state_q == dtqtm_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q;
  assign wr_entry = {stamp_q, pay_q};

  // Enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= s_axis_tuser_i[0];
      src_q   <= s_axis_tuser_i[1];
      stamp_q <= s_axis_tdata_i[31:0];
      pay_q   <= PAYLOAD_BITS'(s_axis_tdata_i[63:32]);
    end
  end

  // Queue memories: read heads on accept, write tail on finish
  always_ff @(posedge clk_i) begin
    if (task_we) begin
      task_mem[task_wr_q] <= wr_entry;
    end
    if (in_xfer) begin
      task_rdata_q <= task_mem[task_rd_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (isr_we) begin
      isr_mem[isr_wr_q] <= wr_entry;
    end
    if (in_xfer) begin
      isr_rdata_q <= isr_mem[isr_rd_q];
    end
  end

  // Execute: merge heads or store the record
  always_comb begin
    logic full, task_has, isr_has, pick_isr;
    logic [dtqtm_pkg::STAMP_W-1:0] t_stamp, i_stamp;
    logic [PAYLOAD_BITS-1:0] t_pay, i_pay;

    task_wr_d   = task_wr_q;
    task_rd_d   = task_rd_q;
    task_fill_d = task_fill_q;
    isr_wr_d    = isr_wr_q;
    isr_rd_d    = isr_rd_q;
    isr_fill_d  = isr_fill_q;
    lost_d      = lost_q;
    task_we     = 1'b0;
    isr_we      = 1'b0;
    res_d       = '0;

    full     = (src_q == dtqtm_pkg::SRC_ISR) ? (isr_fill_q == FullLvl)
                                             : (task_fill_q == FullLvl);
    task_has = (task_fill_q != '0);
    isr_has  = (isr_fill_q != '0);
    t_stamp  = task_rdata_q[EW-1:PAYLOAD_BITS];
    i_stamp  = isr_rdata_q[EW-1:PAYLOAD_BITS];
    t_pay    = task_rdata_q[PAYLOAD_BITS-1:0];
    i_pay    = isr_rdata_q[PAYLOAD_BITS-1:0];
    pick_isr = !task_has || (isr_has && (i_stamp < t_stamp));

    if (finish) begin
      if (op_q == dtqtm_pkg::OP_PUSH) begin
        if (enable_q) begin
          if (full) begin
            if (lost_q != '1) begin
              lost_d = lost_q + 1'b1;
            end
            res_d.push_dropped = 1'b1;
          end else begin
            res_d.push_accepted = 1'b1;
            if (src_q == dtqtm_pkg::SRC_ISR) begin
              isr_we     = 1'b1;
              isr_wr_d   = (isr_wr_q == LastIdx) ? '0 : isr_wr_q + 1'b1;
              isr_fill_d = isr_fill_q + 1'b1;
            end else begin
              task_we     = 1'b1;
              task_wr_d   = (task_wr_q == LastIdx) ? '0 : task_wr_q + 1'b1;
              task_fill_d = task_fill_q + 1'b1;
            end
          end
        end
      end else if (task_has || isr_has) begin
        res_d.pop_valid = 1'b1;
        if (pick_isr) begin
          res_d.pop_source  = dtqtm_pkg::SRC_ISR;
          res_d.pop_stamp   = i_stamp;
          res_d.pop_payload = dtqtm_pkg::PAYOUT_W'(i_pay);
          isr_rd_d   = (isr_rd_q == LastIdx) ? '0 : isr_rd_q + 1'b1;
          isr_fill_d = isr_fill_q - 1'b1;
        end else begin
          res_d.pop_source  = dtqtm_pkg::SRC_TASK;
          res_d.pop_stamp   = t_stamp;
          res_d.pop_payload = dtqtm_pkg::PAYOUT_W'(t_pay);
          task_rd_d   = (task_rd_q == LastIdx) ? '0 : task_rd_q + 1'b1;
          task_fill_d = task_fill_q - 1'b1;
        end
      end
      res_d.lost_total = lost_d;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      dtqtm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = dtqtm_pkg::ST_EXEC;
        end
      end
      dtqtm_pkg::ST_EXEC: begin
        if (finish) begin
          state_d = dtqtm_pkg::ST_IDLE;
        end
      end
      default: state_d = dtqtm_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtqtm_pkg::ST_IDLE;
      task_wr_q   <= '0;
      task_rd_q   <= '0;
      task_fill_q <= '0;
      isr_wr_q    <= '0;
      isr_rd_q    <= '0;
      isr_fill_q  <= '0;
      lost_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      task_wr_q   <= task_wr_d;
      task_rd_q   <= task_rd_d;
      task_fill_q <= task_fill_d;
      isr_wr_q    <= isr_wr_d;
      isr_rd_q    <= isr_rd_d;
      isr_fill_q  <= isr_fill_d;
      lost_q      <= lost_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (task_fill_q <= FullLvl) && (isr_fill_q <= FullLvl))
    else $error("queue fill above depth");

  a_lost_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lost_q >= $past(lost_q))
    else $error("lost counter went down");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !((res_q.push_accepted || res_q.push_dropped) && res_q.pop_valid))
    else $error("result marks both push and pop");

  a_exec_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtqtm_pkg::ST_EXEC) && out_valid_q && !m_axis_tready_i
      |=> (state_q == dtqtm_pkg::ST_EXEC))
    else $error("execute left while result stalled");
`endif

endmodule
